>>> src/nwa_pkg.sv
// nwa_pkg: shared types and constants for the nfa word acceptor
// operation codes, controller states, configuration register indexes, field widths
// no dependencies
`default_nettype none

package nwa_pkg;

  localparam int unsigned OP_W     = 2;
  localparam int unsigned LETTER_W = 5;
  localparam int unsigned STATE_W  = 4;
  localparam int unsigned MASK_W   = 16;
  localparam int unsigned CFG_IDX_W  = 1;
  localparam int unsigned CFG_DATA_W = 16;

  typedef enum logic [OP_W-1:0] {
    OP_ADD_EDGE = 2'd0,
    OP_SYMBOL   = 2'd1,
    OP_END_WORD = 2'd2,
    OP_CLEAR    = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_EXEC
  } state_e;

  localparam logic [CFG_IDX_W-1:0] CFG_START_STATE = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_ACCEPT_MASK = 1'd1;

endpackage

`default_nettype wire

>>> src/nwa_ram.sv
// nwa_ram: generic simple dual port ram, one write and one registered read per cycle
// no dependencies
`default_nettype none

module nwa_ram #(
  parameter int unsigned WIDTH = 256,
  parameter int unsigned DEPTH = 26,
  parameter int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AW-1:0]    waddr_i,
  input  wire logic [WIDTH-1:0] wdata_i,
  input  wire logic [AW-1:0]    raddr_i,
  output logic      [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

>>> src/nfa_word_acceptor.sv
// nfa_word_acceptor: active state set simulation of an nfa over a letter alphabet
// steps: symbol and add edge words read the edge row, then update in the exec state;
// end of word is taken in idle, result registered on the next edge; clear edge table
// sweeps the rows, one edge row zeroed per cycle on the single write port
// reset: async active low; afterwards a clearing pass zeroes the edge rows while
// input is stalled; uses nwa_pkg and nwa_ram
`default_nettype none

module nfa_word_acceptor #(
  parameter int unsigned STATES   = 16,
  parameter int unsigned ALPHABET = 26
) (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  // input words
  input  wire logic                           in_valid_i,
  output logic                                in_stall_o,
  input  wire logic [nwa_pkg::OP_W-1:0]       operation_i,
  input  wire logic [nwa_pkg::LETTER_W-1:0]   letter_i,
  input  wire logic [nwa_pkg::STATE_W-1:0]    from_state_i,
  input  wire logic [nwa_pkg::STATE_W-1:0]    to_state_i,
  // result words
  output logic                                out_valid_o,
  input  wire logic                           out_stall_i,
  output logic                                accepted_o,
  // configuration
  input  wire logic                           cfg_valid_i,
  output logic                                cfg_ready_o,
  input  wire logic [nwa_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  wire logic [nwa_pkg::CFG_DATA_W-1:0] cfg_data_i
);

  import nwa_pkg::*;

  localparam int unsigned ROW_W = STATES * STATES;
  localparam int unsigned AW    = (ALPHABET > 1) ? $clog2(ALPHABET) : 1;
  localparam int unsigned IW    = $clog2(ROW_W);

  function automatic logic [STATES-1:0] start_set(input logic [STATE_W-1:0] s);
    logic [STATES-1:0] r;
    r = '0;
    if (32'(s) < STATES) begin
      r = STATES'(1) << s;
    end
    return r;
  endfunction

  state_e            state_q, state_d;
  op_e               op_q;
  logic              letter_ok_q;
  logic              edge_ok_q;
  logic [IW-1:0]     edge_idx_q;
  logic [AW-1:0]     row_q;
  logic [AW-1:0]     clr_cnt_q, clr_cnt_d;
  logic [STATES-1:0] active_q, active_d;
  logic [STATE_W-1:0] start_q;
  logic [MASK_W-1:0] accept_q;
  logic              out_valid_q, out_valid_d;
  logic              out_acc_q, out_acc_d;

  logic              in_acc;
  logic              cfg_we;
  op_e               in_op;
  logic              clr_last;

  logic              ram_we;
  logic [AW-1:0]     ram_waddr;
  logic [ROW_W-1:0]  ram_wdata;
  logic [AW-1:0]     ram_raddr;
  logic [ROW_W-1:0]  ram_rdata;

  logic [STATES-1:0] succ;
  logic [STATES-1:0] final_set;

  assign in_op    = op_e'(operation_i);
  assign in_acc   = in_valid_i && !in_stall_o;
  assign cfg_ready_o = 1'b1;
  assign cfg_we   = cfg_valid_i && cfg_ready_o;
  assign clr_last = (clr_cnt_q == AW'(ALPHABET - 1));

  // final states at or above the register width are never final
  for (genvar i = 0; i < STATES; i++) begin : g_final
    if (i < MASK_W) begin : g_in
      assign final_set[i] = accept_q[i];
    end else begin : g_out
      assign final_set[i] = 1'b0;
    end
  end

  // union of the successor masks of all active states for the row just read
  always_comb begin
    succ = '0;
    for (int q = 0; q < STATES; q++) begin
      if (active_q[q]) begin
        succ = succ | ram_rdata[q*STATES +: STATES];
      end
    end
  end

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_CLEAR: begin
        if (clr_last) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (in_acc) begin
          case (in_op)
            OP_ADD_EDGE: state_d = ST_EXEC;
            OP_SYMBOL:   state_d = ST_EXEC;
            OP_CLEAR:    state_d = ST_CLEAR;
            default:     state_d = ST_IDLE;
          endcase
        end
      end
      ST_EXEC: state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  // outputs of the controller
  always_comb begin
    in_stall_o = 1'b1;
    ram_we     = 1'b0;
    ram_waddr  = row_q;
    ram_wdata  = ram_rdata | (ROW_W'(1) << edge_idx_q);
    ram_raddr  = AW'(letter_i);
    clr_cnt_d  = clr_cnt_q;
    case (state_q)
      ST_CLEAR: begin
        ram_we    = 1'b1;
        ram_waddr = clr_cnt_q;
        ram_wdata = '0;
        clr_cnt_d = clr_cnt_q + AW'(1);
      end
      ST_IDLE: begin
        // a waiting result only blocks when it is not taken this cycle
        in_stall_o = out_valid_q && out_stall_i;
        clr_cnt_d  = '0;
      end
      ST_EXEC: begin
        ram_we = (op_q == OP_ADD_EDGE) && edge_ok_q;
      end
      default: begin
        in_stall_o = 1'b1;
      end
    endcase
  end

  always_comb begin
    active_d    = active_q;
    out_valid_d = out_valid_q && out_stall_i;
    out_acc_d   = out_acc_q;
    if (cfg_we && cfg_index_i == CFG_START_STATE) begin
      active_d = start_set(cfg_data_i[STATE_W-1:0]);
    end else if (in_acc && in_op == OP_END_WORD) begin
      out_valid_d = 1'b1;
      out_acc_d   = |(active_q & final_set);
      active_d    = start_set(start_q);
    end else if (state_q == ST_EXEC && op_q == OP_SYMBOL) begin
      active_d = letter_ok_q ? succ : '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      clr_cnt_q   <= '0;
      active_q    <= STATES'(1);
      start_q     <= '0;
      accept_q    <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      clr_cnt_q   <= clr_cnt_d;
      active_q    <= active_d;
      out_valid_q <= out_valid_d;
      if (cfg_we && cfg_index_i == CFG_START_STATE) begin
        start_q <= cfg_data_i[STATE_W-1:0];
      end
      if (cfg_we && cfg_index_i == CFG_ACCEPT_MASK) begin
        accept_q <= cfg_data_i[MASK_W-1:0];
      end
    end
  end

  // word payload, captured at accept
  always_ff @(posedge clk_i) begin
    out_acc_q <= out_acc_d;
    if (in_acc) begin
      op_q        <= in_op;
      row_q       <= AW'(letter_i);
      letter_ok_q <= 32'(letter_i) < ALPHABET;
      edge_ok_q   <= (32'(letter_i) < ALPHABET) && (32'(from_state_i) < STATES)
                     && (32'(to_state_i) < STATES);
      edge_idx_q  <= IW'(32'(from_state_i) * STATES + 32'(to_state_i));
    end
  end

  nwa_ram #(
    .WIDTH (ROW_W),
    .DEPTH (ALPHABET),
    .AW    (AW)
  ) u_edge_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  assign out_valid_o = out_valid_q;
  assign accepted_o  = out_acc_q;

`ifndef SYNTHESIS
  a_no_write_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_IDLE) |-> !ram_we)
    else $error("edge ram written while idle");

  a_busy_stalls: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != ST_IDLE) |-> in_stall_o)
    else $error("word accepted while busy");

  a_end_gives_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && in_op == OP_END_WORD) |=> out_valid_o)
    else $error("end of word without result");

  a_exec_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_EXEC) |-> $past(in_acc))
    else $error("update without an accepted word");

  a_sweep_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_CLEAR) |-> (32'(clr_cnt_q) < ALPHABET))
    else $error("clearing pass beyond the edge rows");
`endif

endmodule

`default_nettype wire
